/* src/jfms_pkg.sv */
// ----------------------------------------------------------------------------
// JPEG frame marker scanner package
// Shared widths, marker codes, outcome codes and the types that travel
// between the scanner's modules.
// ----------------------------------------------------------------------------
package jfms_pkg;

	localparam int unsigned OffW = 16;
	localparam int unsigned LenW = 17;
	localparam int unsigned DefaultBufferBytes = 65536;
	localparam int unsigned LenMax = (1 << LenW) - 1;

	localparam logic [7:0] MARK_PREFIX = 8'hFF;
	localparam logic [7:0] MARK_SOI    = 8'hD8;
	localparam logic [7:0] MARK_EOI    = 8'hD9;

	typedef enum logic [1:0] {
		OUTCOME_IMAGE      = 2'd0,
		OUTCOME_SECOND_SOI = 2'd1,
		OUTCOME_WRAPPED    = 2'd2
	} outcome_t;

	typedef struct packed {
		logic            new_search;
		logic [7:0]      data_byte;
		logic [OffW-1:0] byte_offset;
	} scan_item_t;

	typedef struct packed {
		logic            valid;
		outcome_t        outcome;
		logic [OffW-1:0] start_offset;
		logic [OffW-1:0] end_offset;
		logic [OffW-1:0] image_size;
	} scan_res_t;

endpackage

/* src/jfms_if.sv */
// ----------------------------------------------------------------------------
// JPEG frame marker scanner channels
// Valid/ready channels for incoming bytes, outgoing results and the
// buffer length register write.
// ----------------------------------------------------------------------------
interface jfms_byte_if;
	logic        valid;
	logic        ready;
	logic        new_search;
	logic [7:0]  data_byte;
	logic [15:0] byte_offset;

	modport source (output valid, new_search, data_byte, byte_offset, input ready);
	modport sink   (input valid, new_search, data_byte, byte_offset, output ready);
endinterface

interface jfms_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  outcome;
	logic [15:0] start_offset;
	logic [15:0] end_offset;
	logic [15:0] image_size;

	modport source (output valid, outcome, start_offset, end_offset, image_size,
		input ready);
	modport sink   (input valid, outcome, start_offset, end_offset, image_size,
		output ready);
endinterface

interface jfms_cfg_if;
	logic        valid;
	logic        ready;
	logic [16:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

/* src/jfms_scan.sv */
// ----------------------------------------------------------------------------
// JPEG frame marker scanner core
// Holds the search state and decides, for one registered byte, the state
// update and whether a result is produced.
// ----------------------------------------------------------------------------
module jfms_scan
	import jfms_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  scan_item_t      item,
	input  logic [LenW-1:0] buffer_length,
	output scan_res_t       res
);

	logic [7:0]      previous_byte_q;
	logic            previous_valid_q;
	logic            start_seen_q;
	logic [OffW-1:0] start_position_q;
	logic            buffer_end_passed_q;
	logic            search_done_q;

	logic [7:0]      previous_byte_d;
	logic            previous_valid_d;
	logic            start_seen_d;
	logic [OffW-1:0] start_position_d;
	logic            buffer_end_passed_d;
	logic            search_done_d;

	always_comb begin
		logic            fresh;
		logic            prev_valid_e;
		logic            start_seen_e;
		logic [OffW-1:0] start_pos_e;
		logic            passed_e;
		logic            at_zero;
		logic            pair_ff;
		logic [OffW-1:0] mark_pos;

		fresh        = item.new_search;
		prev_valid_e = fresh ? 1'b0 : previous_valid_q;
		start_seen_e = fresh ? 1'b0 : start_seen_q;
		start_pos_e  = fresh ? '0 : start_position_q;
		passed_e     = fresh ? 1'b0 : buffer_end_passed_q;
		at_zero      = (item.byte_offset == '0);
		pair_ff      = prev_valid_e && (previous_byte_q == MARK_PREFIX) && !at_zero;
		mark_pos     = item.byte_offset - OffW'(1);

		previous_byte_d     = previous_byte_q;
		previous_valid_d    = previous_valid_q;
		start_seen_d        = start_seen_q;
		start_position_d    = start_position_q;
		buffer_end_passed_d = buffer_end_passed_q;
		search_done_d       = search_done_q;

		res              = '0;
		res.outcome      = OUTCOME_IMAGE;

		if (fresh || !search_done_q) begin
			previous_valid_d    = prev_valid_e;
			start_seen_d        = start_seen_e;
			start_position_d    = start_pos_e;
			buffer_end_passed_d = passed_e;
			search_done_d       = 1'b0;

			// A second arrival at offset zero ends the search before the byte
			// is looked at as part of a marker.
			if (!fresh && at_zero && passed_e) begin
				search_done_d    = 1'b1;
				res.valid        = 1'b1;
				res.outcome      = OUTCOME_WRAPPED;
				res.start_offset = start_seen_e ? start_pos_e : '0;
			end else begin
				if (!fresh && at_zero) begin
					buffer_end_passed_d = 1'b1;
				end
				previous_byte_d  = item.data_byte;
				previous_valid_d = 1'b1;

				if (pair_ff && item.data_byte == MARK_SOI) begin
					if (start_seen_e) begin
						search_done_d    = 1'b1;
						res.valid        = 1'b1;
						res.outcome      = OUTCOME_SECOND_SOI;
						res.start_offset = start_pos_e;
					end else begin
						start_seen_d     = 1'b1;
						start_position_d = mark_pos;
					end
				end else if (pair_ff && item.data_byte == MARK_EOI && start_seen_e) begin
					search_done_d    = 1'b1;
					res.valid        = 1'b1;
					res.outcome      = OUTCOME_IMAGE;
					res.start_offset = start_pos_e;
					res.end_offset   = mark_pos;
					if (mark_pos > start_pos_e) begin
						res.image_size = mark_pos - start_pos_e;
					end else if (mark_pos < start_pos_e) begin
						// The image wraps around the end of the buffer.
						res.image_size = buffer_length[OffW-1:0] - start_pos_e + mark_pos;
					end else begin
						res.image_size = '0;
					end
				end
			end
		end

		if (!step) begin
			res.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			previous_byte_q     <= '0;
			previous_valid_q    <= 1'b0;
			start_seen_q        <= 1'b0;
			start_position_q    <= '0;
			buffer_end_passed_q <= 1'b0;
			search_done_q       <= 1'b1;
		end else if (step) begin
			previous_byte_q     <= previous_byte_d;
			previous_valid_q    <= previous_valid_d;
			start_seen_q        <= start_seen_d;
			start_position_q    <= start_position_d;
			buffer_end_passed_q <= buffer_end_passed_d;
			search_done_q       <= search_done_d;
		end
	end

	// Every result closes the search.
	a_result_closes: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |=> search_done_q)
		else $error("result produced without closing the search");

	// Only a found image carries an end offset and a size.
	a_unused_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.outcome != OUTCOME_IMAGE |-> res.end_offset == '0 &&
			res.image_size == '0)
		else $error("end offset or size set without an image");

	// The start position stays cleared until a start marker is seen.
	a_start_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		!start_seen_q |-> start_position_q == '0)
		else $error("start position set without a start marker");

	// A byte ignored while idle leaves the state alone.
	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		step && search_done_q && !item.new_search |=> search_done_q &&
			$stable(previous_byte_q) && $stable(start_position_q))
		else $error("state changed while idle");

endmodule

/* src/jpeg_frame_marker_scanner_unit.sv */
// ----------------------------------------------------------------------------
// JPEG frame marker scanner
// Finds one JPEG frame (start and end marker pair) in a circular buffer.
// ----------------------------------------------------------------------------
// Usage:
// Bytes enter on the scan channel with their buffer offset; a beat with
// new_search set starts a fresh search. Each search ends with one beat on
// the result channel: an image with start, end and wrap-aware size, a second
// start marker, or the buffer passed twice. Until the next new_search beat,
// bytes are taken and dropped.
// The cfg channel writes the buffer length used for the wrap-around size; it
// is always ready. The user must write it only while no byte is in flight;
// the block does not enforce this. Throughput is one byte per cycle while
// the result channel is not stalled. A byte goes through an input register
// and the scan logic into the result register.
// When the receiver stalls, the pending result holds; the byte in the input
// register waits and scan.ready drops, so at most one byte is held.
// After reset no search is active, the buffer length is BUFFER_BYTES
// (saturated to 17 bits) and both channels are empty.
// ----------------------------------------------------------------------------
module jpeg_frame_marker_scanner_unit
	import jfms_pkg::*;
#(
	parameter int unsigned BUFFER_BYTES = DefaultBufferBytes
) (
	input  logic          clk,
	input  logic          arst_n,
	jfms_byte_if.sink     scan,
	jfms_result_if.source result,
	jfms_cfg_if.sink      cfg
);

	localparam logic [LenW-1:0] LenReset =
		(BUFFER_BYTES > LenMax) ? LenW'(LenMax) : LenW'(BUFFER_BYTES);

	logic [LenW-1:0] buffer_length_q;
	logic            valid_s1;
	scan_item_t      item_s1;
	logic            out_valid_q;
	scan_res_t       res_q;
	scan_res_t       res;
	logic            fire_s1;
	logic            accept;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_length_q <= LenReset;
		end else if (cfg.valid) begin
			buffer_length_q <= cfg.data;
		end
	end

	assign fire_s1    = valid_s1 && (!out_valid_q || result.ready);
	assign scan.ready = !valid_s1 || fire_s1;
	assign accept     = scan.valid && scan.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan.ready) begin
			valid_s1 <= scan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.new_search  <= scan.new_search;
			item_s1.data_byte   <= scan.data_byte;
			item_s1.byte_offset <= scan.byte_offset;
		end
	end

	jfms_scan u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (fire_s1),
		.item          (item_s1),
		.buffer_length (buffer_length_q),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			res_q <= res;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.outcome      = res_q.outcome;
	assign result.start_offset = res_q.start_offset;
	assign result.end_offset   = res_q.end_offset;
	assign result.image_size   = res_q.image_size;

	// A new result is only written into a free or draining result register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !out_valid_q || result.ready)
		else $error("pending result overwritten");

	// Backpressure on the byte side comes only from a stalled result.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!scan.ready |-> valid_s1 && out_valid_q && !result.ready)
		else $error("scan channel stalled without a stalled result");

	// A held byte is processed in the cycle the result is taken.
	a_drain_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && result.ready |-> fire_s1)
		else $error("held byte not processed when result drained");

endmodule
